// ----- rtl/core/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg
// shared types and codes for the hashed timer wheel
// ----------------------------------------------------------------------------
`default_nettype none
package htw_pkg;
	localparam int NUM_TIMERS = 32;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_CANCEL,
		ST_TICK_HEAD,
		ST_TICK_POP,
		ST_TICK_FILE,
		ST_EMIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  timer_id;
		logic [31:0] duration;
		logic        periodic;
	} in_item_t;

	typedef struct packed {
		logic       status;
		logic       expired_valid;
		logic [4:0] expired_id;
		logic       last;
	} out_item_t;
endpackage
`default_nettype wire

// ----- rtl/core/htw_if.sv -----
// ----------------------------------------------------------------------------
// htw_in_if / htw_out_if
// valid/ready channels carrying the input and result items
// ----------------------------------------------------------------------------
`default_nettype none
interface htw_in_if import htw_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface htw_out_if import htw_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/hashed_timer_wheel_core.sv -----
// ----------------------------------------------------------------------------
// hashed_timer_wheel_core
// hashed timing wheel with per-slot fifo timer lists and a step sequencer
// ----------------------------------------------------------------------------
// One item at a time. Start and cancel pass through their own state to DONE.
// A tick unlinks each timer at the current slot's head, re-files it by its
// remainder (or its period, if expired and periodic) and emits it if expired,
// until the slot is empty; EMIT and DONE wait while the result sink stalls.
// All of it runs through one list sequencer with registered reads of the slot
// head/tail tables and one filing unit for slot targets and remainders. Every
// item yields at least one result item through a one-entry output register;
// the latest expiry of a tick is held back so that it can carry last. The next
// item is taken once the last result has left. After reset a clearing pass
// over all NUM_SLOTS slots sets head and tail tables empty before any accept.
`default_nettype none
module hashed_timer_wheel_core import htw_pkg::*; #(
	parameter int NUM_SLOTS  = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	htw_in_if.sink    in_ch,
	htw_out_if.source out_ch
);
	localparam int SW = $clog2(NUM_SLOTS);
	localparam int TW = $clog2(NUM_TIMERS + 1);
	localparam logic [TW-1:0] NIL = TW'(NUM_TIMERS);

	state_t state_q, state_d;

	logic [TW-1:0] head_mem [NUM_SLOTS];
	logic [TW-1:0] tail_mem [NUM_SLOTS];
	logic [TW-1:0] next_q   [NUM_TIMERS];
	logic [TW-1:0] prev_q   [NUM_TIMERS];
	logic [SW-1:0] home_q   [NUM_TIMERS];
	logic [31:0]   dur_q    [NUM_TIMERS];
	logic [31:0]   rem_q    [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] run_q, listed_q, per_q;

	logic [SW-1:0] cur_q;
	logic          clr_q;
	logic [SW-1:0] clr_cnt_q;
	in_item_t      item_q;
	logic [5:0]    nres_q;
	out_item_t     res_q;
	logic          res_v_q;
	logic          pend_v_q;
	logic [4:0]    pend_id_q;
	logic          sts_q;

	// registered slot table reads
	logic [TW-1:0] head_rd_q, tail_rd_q;

	logic [TW-1:0] id_t, t_q;
	assign id_t = TW'(item_q.timer_id);
	logic id_ok;
	assign id_ok = {1'b0, item_q.timer_id} < 6'(NUM_TIMERS);

	logic [31:0] t_rem, t_dur;
	assign t_rem = rem_q[t_q[TW-2:0]];
	assign t_dur = dur_q[t_q[TW-2:0]];

	// shared filing unit: target slot and remainder for duration f_dur
	logic [31:0]   f_dur;
	logic          f_avoid;
	logic [SW-1:0] f_slot;
	logic [31:0]   f_rem;
	always_comb begin
		f_rem  = 32'd0;
		if (f_dur >= 32'(NUM_SLOTS)) begin
			f_rem  = f_dur - 32'(NUM_SLOTS) + 32'd1;
			f_slot = cur_q - SW'(1);
		end else begin
			f_slot = cur_q + f_dur[SW-1:0];
		end
		if (f_avoid && f_slot == cur_q)
			f_slot = cur_q + SW'(1);
	end

	logic [TW-1:0] u_p, u_n;
	logic [SW-1:0] u_s;

	// output
	logic      out_free;
	logic      res_load;
	out_item_t res_d;
	assign out_free     = !res_v_q || out_ch.ready;
	assign out_ch.valid = res_v_q;
	assign out_ch.data  = res_q;
	assign in_ch.ready  = (state_q == ST_IDLE) && !clr_q && !res_v_q;

	logic [TW-1:0] u_t;
	always_comb begin
		state_d = state_q;
		u_t     = (state_q == ST_CANCEL) ? id_t : t_q;
		f_dur   = item_q.duration;
		f_avoid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				f_dur = in_ch.data.duration;
				if (in_ch.valid && in_ch.ready) begin
					case (in_ch.data.cmd)
						CMD_START:  state_d = ST_START;
						CMD_CANCEL: state_d = ST_CANCEL;
						CMD_TICK:   state_d = ST_TICK_HEAD;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_START:     state_d = ST_DONE;
			ST_CANCEL:    state_d = ST_DONE;
			ST_TICK_HEAD: state_d = (head_rd_q == NIL) ? ST_DONE : ST_TICK_POP;
			ST_TICK_POP: begin
				f_avoid = 1'b1;
				f_dur   = (t_rem != 32'd0) ? t_rem : t_dur;
				state_d = ST_TICK_FILE;
			end
			ST_TICK_FILE: begin
				f_avoid = 1'b1;
				f_dur   = (t_rem != 32'd0) ? t_rem : t_dur;
				state_d = (t_rem == 32'd0) ? ST_EMIT : ST_TICK_HEAD;
			end
			ST_EMIT:
				if (!pend_v_q || nres_q >= 6'd32 || out_free) state_d = ST_TICK_HEAD;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end
	assign u_s = home_q[u_t[TW-2:0]];
	assign u_p = prev_q[u_t[TW-2:0]];
	assign u_n = next_q[u_t[TW-2:0]];

	// result register load
	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			ST_EMIT: if (pend_v_q && nres_q < 6'd32 && out_free) begin
				res_load = 1'b1;
				res_d    = '{status: 1'b0, expired_valid: 1'b1,
					expired_id: pend_id_q, last: 1'b0};
			end
			ST_DONE: if (out_free) begin
				res_load = 1'b1;
				if (pend_v_q)
					res_d = '{status: 1'b0, expired_valid: 1'b1,
						expired_id: pend_id_q, last: 1'b1};
				else
					res_d = '{status: sts_q, expired_valid: 1'b0,
						expired_id: 5'd0, last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// unlink timer u_t or append timer to slot f_slot
	logic do_unlink, do_append;
	logic [TW-1:0] ap_t;
	always_comb begin
		do_unlink = 1'b0;
		do_append = 1'b0;
		ap_t      = id_t;
		case (state_q)
			ST_START:     do_append = id_ok && !listed_q[id_t[TW-2:0]];
			ST_CANCEL:    do_unlink = id_ok && run_q[id_t[TW-2:0]] &&
				listed_q[id_t[TW-2:0]];
			ST_TICK_POP:  do_unlink = 1'b1;
			ST_TICK_FILE: begin
				ap_t      = t_q;
				do_append = (t_rem != 32'd0) || per_q[t_q[TW-2:0]];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			head_mem[clr_cnt_q] <= NIL;
			tail_mem[clr_cnt_q] <= NIL;
		end else if (do_unlink) begin
			if (u_p == NIL) head_mem[u_s] <= u_n;
			else next_q[u_p[TW-2:0]] <= u_n;
			if (u_n == NIL) tail_mem[u_s] <= u_p;
			else prev_q[u_n[TW-2:0]] <= u_p;
			next_q[u_t[TW-2:0]] <= NIL;
			prev_q[u_t[TW-2:0]] <= NIL;
		end else if (do_append) begin
			prev_q[ap_t[TW-2:0]] <= tail_rd_q;
			next_q[ap_t[TW-2:0]] <= NIL;
			if (tail_rd_q == NIL) head_mem[f_slot] <= ap_t;
			else next_q[tail_rd_q[TW-2:0]] <= ap_t;
			tail_mem[f_slot] <= ap_t;
			home_q[ap_t[TW-2:0]] <= f_slot;
			rem_q[ap_t[TW-2:0]]  <= f_rem;
		end
		head_rd_q <= head_mem[cur_q];
		tail_rd_q <= tail_mem[f_slot];
		if (state_q == ST_START && do_append)
			dur_q[id_t[TW-2:0]] <= item_q.duration;
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready)
			item_q <= in_ch.data;
		if (state_q == ST_TICK_HEAD)
			t_q <= head_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			cur_q     <= '0;
			run_q     <= '0;
			listed_q  <= '0;
			per_q     <= '0;
			nres_q    <= '0;
			res_v_q   <= 1'b0;
			res_q     <= '0;
			pend_v_q  <= 1'b0;
			pend_id_q <= '0;
			sts_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + SW'(1);
				if (clr_cnt_q == SW'(NUM_SLOTS - 1)) clr_q <= 1'b0;
			end
			if (res_load) begin
				res_v_q <= 1'b1;
				res_q   <= res_d;
			end else if (out_ch.ready) begin
				res_v_q <= 1'b0;
			end
			if (state_q == ST_IDLE) nres_q <= '0;
			if (do_unlink) listed_q[u_t[TW-2:0]] <= 1'b0;
			if (do_append) listed_q[ap_t[TW-2:0]] <= 1'b1;
			case (state_q)
				ST_IDLE: sts_q <= 1'b0;
				ST_START: begin
					sts_q <= !id_ok || listed_q[id_t[TW-2:0]];
					if (do_append) begin
						run_q[id_t[TW-2:0]] <= 1'b1;
						per_q[id_t[TW-2:0]] <= item_q.periodic;
					end
				end
				ST_CANCEL: if (id_ok) run_q[id_t[TW-2:0]] <= 1'b0;
				ST_TICK_HEAD: if (head_rd_q == NIL) cur_q <= cur_q + SW'(1);
				ST_TICK_FILE:
					if (t_rem == 32'd0 && !per_q[t_q[TW-2:0]])
						run_q[t_q[TW-2:0]] <= 1'b0;
				ST_EMIT: if (nres_q < 6'd32 && (!pend_v_q || out_free)) begin
					pend_v_q  <= 1'b1;
					pend_id_q <= 5'(t_q);
					nres_q    <= nres_q + 6'd1;
				end
				ST_DONE: if (out_free) pend_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ch.ready) else $error("accept during clear");
	a_nres_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= 6'd32) else $error("result count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !out_ch.ready) |=> (res_v_q && $stable(res_q)))
		else $error("result item changed while waiting");
endmodule
`default_nettype wire
